// File: rtl/prcd_pkg.sv
package prcd_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_DELAY = 2'd3
  } prcd_cmd_e;

  localparam logic [7:0] OP_SWITCH  = 8'd1;
  localparam logic [7:0] OP_MUTE    = 8'd2;
  localparam logic [7:0] OP_STANDBY = 8'd3;
  localparam logic [7:0] OP_RADIO   = 8'd4;

  localparam logic [1:0] CountMax = 2'd3;

  localparam logic [7:0] B_TUNER = 8'h01;
  localparam logic [7:0] B_CD    = 8'h02;
  localparam logic [7:0] B_AUX   = 8'h04;
  localparam logic [7:0] B_TC12  = 8'h08;
  localparam logic [7:0] B_TAPE2 = 8'h10;
  localparam logic [7:0] B_TAPE1 = 8'h20;
  localparam logic [7:0] B_TMON  = 8'h40;
  localparam logic [7:0] B_TC21  = 8'h80;

  localparam logic [7:0] ALL_OFF    = B_AUX | B_CD | B_TUNER | B_TAPE1 | B_TAPE2 | B_TC12 | B_TC21;
  localparam logic [7:0] INPUTS_OFF = B_AUX | B_CD | B_TUNER | B_TAPE1 | B_TAPE2;
  localparam logic [7:0] ROUTING_RST = 8'hBD;

  typedef struct packed {
    logic [7:0] relay_pattern;
    logic       standby_line;
    logic       radio_reset_line;
  } prcd_status_t;

  function automatic logic [7:0] decode_route(input logic [7:0] sel);
    logic [7:0] p;
    p = ALL_OFF;
    case (sel[1:0])
      2'd0:    p = p & ~B_AUX;
      2'd2:    p = p & ~B_TUNER;
      default: p = p & ~B_CD;
    endcase
    case (sel[3:2])
      2'd1:    p = (p & ~B_TAPE1) | B_TMON;
      2'd2:    p = (p & ~B_TAPE2) | B_TMON;
      default: p = p;
    endcase
    case (sel[5:4])
      2'd1:    p = p & ~B_TC12;
      2'd2:    p = p & ~B_TC21;
      default: p = p;
    endcase
    return p;
  endfunction

endpackage

// File: rtl/prcd_if.sv
interface prcd_evt_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface prcd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] relay_pattern;
  logic       standby_line;
  logic       radio_reset_line;

  modport source (output valid, output relay_pattern, output standby_line,
                  output radio_reset_line, input ready);
  modport sink   (input valid, input relay_pattern, input standby_line,
                  input radio_reset_line, output ready);
endinterface

// File: rtl/preamp_routing_command_decoder_unit.sv
// Preamp routing command decoder. Takes address-matched bus events (start, data
// byte, stop, radio reset delay elapsed) and returns, for every event, one result
// with the relay pattern, standby line and radio reset line as they stand after
// it. One event is taken per cycle while results are accepted; each passes the
// input register, the single decode and state update stage and the result
// register. A stalled result holds the pipeline.
module preamp_routing_command_decoder_unit import prcd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  prcd_evt_if.sink   evt_i,
  prcd_res_if.source res_o
);

  logic         in_vld_q;
  logic [1:0]   cmd_q;
  logic [7:0]   data_q;
  logic         out_vld_q;
  prcd_status_t res_q;
  prcd_status_t status;
  logic         advance;

  assign advance     = in_vld_q && (!out_vld_q || res_o.ready);
  assign evt_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (evt_i.ready) begin
        in_vld_q <= evt_i.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      cmd_q  <= evt_i.command;
      data_q <= evt_i.data_byte;
    end
    if (advance) begin
      res_q <= status;
    end
  end

  prcd_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .cmd_i    (cmd_q),
    .data_i   (data_q),
    .status_o (status)
  );

  assign res_o.valid            = out_vld_q;
  assign res_o.relay_pattern    = res_q.relay_pattern;
  assign res_o.standby_line     = res_q.standby_line;
  assign res_o.radio_reset_line = res_q.radio_reset_line;

endmodule

// File: rtl/prcd_state.sv
module prcd_state import prcd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [1:0]   cmd_i,
  input  logic [7:0]   data_i,
  output prcd_status_t status_o
);

  logic [1:0] count_q, count_d;
  logic [7:0] frame_q [2];
  logic [7:0] routing_q, routing_d;
  logic [7:0] saved_q, saved_d;
  logic       standby_q, standby_d;
  logic       radio_q, radio_d;
  logic       store;

  always_comb begin
    count_d   = count_q;
    routing_d = routing_q;
    saved_d   = saved_q;
    standby_d = standby_q;
    radio_d   = radio_q;
    store     = 1'b0;
    case (prcd_cmd_e'(cmd_i))
      CMD_START: begin
        count_d = '0;
      end
      CMD_BYTE: begin
        if (count_q != CountMax) begin
          store   = ~count_q[1];
          count_d = count_q + 2'd1;
        end
      end
      CMD_STOP: begin
        if (count_q != '0) begin
          if (count_q == 2'd2) begin
            case (frame_q[0])
              OP_SWITCH: begin
                routing_d = decode_route(frame_q[1]);
                saved_d   = '0;
                standby_d = 1'b0;
              end
              OP_MUTE: begin
                if (frame_q[1] != '0) begin
                  if (saved_q == '0) begin
                    saved_d   = routing_q;
                    routing_d = (routing_q | INPUTS_OFF) & ~B_TMON;
                  end
                end else if (saved_q != '0) begin
                  routing_d = saved_q;
                  saved_d   = '0;
                end
              end
              OP_STANDBY: begin
                standby_d = (frame_q[1] != '0);
              end
              default: ;
            endcase
          end else if (frame_q[0] == OP_RADIO) begin
            radio_d = 1'b0;
          end
          count_d = '0;
        end
      end
      CMD_DELAY: begin
        radio_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      routing_q <= ROUTING_RST;
      saved_q   <= '0;
      standby_q <= 1'b0;
      radio_q   <= 1'b1;
    end else if (en_i) begin
      count_q   <= count_d;
      routing_q <= routing_d;
      saved_q   <= saved_d;
      standby_q <= standby_d;
      radio_q   <= radio_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && store) begin
      frame_q[count_q[0]] <= data_i;
    end
  end

  assign status_o.relay_pattern    = routing_d;
  assign status_o.standby_line     = standby_d;
  assign status_o.radio_reset_line = radio_d;

endmodule

// File: test/preamp_routing_command_decoder_unit_tb.sv
`timescale 1ns / 1ps

module preamp_routing_command_decoder_unit_tb;
  import prcd_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldOffCycles = 100;
  localparam int unsigned DrainCycles = 10;

  logic clk;
  logic rst_n;

  prcd_evt_if evt ();
  prcd_res_if res ();

  preamp_routing_command_decoder_unit dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .evt_i (evt.sink),
    .res_o (res.source)
  );

  // panel state as the block should hold it
  logic [1:0] byte_cnt;
  logic [7:0] frame_buf [2];
  logic [7:0] route_now;
  logic [7:0] route_saved;
  logic       standby_now;
  logic       radio_now;

  prcd_status_t expected_status_q [$];

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned hold_left;
  int unsigned events_sent;
  int unsigned fail_count;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] relay_for_selection(logic [7:0] sel);
    logic [7:0] pat;
    pat = ALL_OFF;
    if (sel[1:0] == 2'd0) pat[2] = 1'b0;
    else if (sel[1:0] == 2'd2) pat[0] = 1'b0;
    else pat[1] = 1'b0;
    if (sel[3:2] == 2'd1) begin
      pat[5] = 1'b0;
      pat[6] = 1'b1;
    end else if (sel[3:2] == 2'd2) begin
      pat[4] = 1'b0;
      pat[6] = 1'b1;
    end
    if (sel[5:4] == 2'd1) pat[3] = 1'b0;
    else if (sel[5:4] == 2'd2) pat[7] = 1'b0;
    return pat;
  endfunction

  task automatic run_frame_command(logic [7:0] op, logic [7:0] arg);
    if (op == OP_SWITCH) begin
      route_now   = relay_for_selection(arg);
      route_saved = 8'h00;
      standby_now = 1'b0;
    end else if (op == OP_MUTE) begin
      if (arg != 8'h00) begin
        if (route_saved == 8'h00) begin
          route_saved = route_now;
          route_now   = (route_now | INPUTS_OFF) & ~B_TMON;
        end
      end else if (route_saved != 8'h00) begin
        route_now   = route_saved;
        route_saved = 8'h00;
      end
    end else if (op == OP_STANDBY) begin
      standby_now = (arg != 8'h00);
    end
  endtask

  task automatic update_panel_state(prcd_cmd_e cmd, logic [7:0] data);
    prcd_status_t st;
    case (cmd)
      CMD_START: byte_cnt = 2'd0;
      CMD_BYTE: begin
        if (byte_cnt < CountMax) begin
          if (byte_cnt < 2'd2) frame_buf[byte_cnt[0]] = data;
          byte_cnt = byte_cnt + 2'd1;
        end
      end
      CMD_STOP: begin
        if (byte_cnt != 2'd0) begin
          if (byte_cnt == 2'd2) run_frame_command(frame_buf[0], frame_buf[1]);
          else if (frame_buf[0] == OP_RADIO) radio_now = 1'b0;
          byte_cnt = 2'd0;
        end
      end
      default: radio_now = 1'b1;
    endcase
    st.relay_pattern    = route_now;
    st.standby_line     = standby_now;
    st.radio_reset_line = radio_now;
    expected_status_q.push_back(st);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  // called at a rising edge; returns at the edge of the transfer
  task automatic send_event(prcd_cmd_e cmd, logic [7:0] data);
    while ($urandom_range(99) < src_idle_pct) begin
      evt.valid <= 1'b0;
      @(posedge clk);
    end
    evt.valid     <= 1'b1;
    evt.command   <= cmd;
    evt.data_byte <= data;
    do @(posedge clk); while (evt.ready !== 1'b1);
    update_panel_state(cmd, data);
    events_sent++;
  endtask

  task automatic send_byte_frame(logic [7:0] op, logic [7:0] arg);
    send_event(CMD_START, 8'($urandom_range(255)));
    send_event(CMD_BYTE, op);
    send_event(CMD_BYTE, arg);
    send_event(CMD_STOP, 8'($urandom_range(255)));
  endtask

  task automatic send_random_frame();
    int unsigned kind;
    int unsigned pick;
    int unsigned nbytes;
    logic [7:0] op;
    logic [7:0] arg;
    kind = $urandom_range(99);
    if (kind < 15) begin
      send_event(prcd_cmd_e'($urandom_range(3)), 8'($urandom_range(255)));
      return;
    end
    case ($urandom_range(6))
      0, 1:    op = OP_SWITCH;
      2:       op = OP_MUTE;
      3:       op = OP_STANDBY;
      4:       op = OP_RADIO;
      5:       op = OP_MUTE;
      default: op = 8'($urandom_range(255));
    endcase
    arg = 8'($urandom_range(255));
    if (op != OP_SWITCH && $urandom_range(1) == 0) arg = 8'h00;
    pick = $urandom_range(99);
    if (pick < 70) nbytes = 2;
    else if (pick < 80) nbytes = 1;
    else if (pick < 90) nbytes = 3;
    else nbytes = $urandom_range(5, 4);
    if (kind >= 20) send_event(CMD_START, 8'($urandom_range(255)));
    send_event(CMD_BYTE, op);
    if (nbytes >= 2) send_event(CMD_BYTE, arg);
    for (int unsigned i = 2; i < nbytes; i++) send_event(CMD_BYTE, 8'($urandom_range(255)));
    if (kind < 95) send_event(CMD_STOP, 8'($urandom_range(255)));
    if ($urandom_range(99) < 30) send_event(CMD_DELAY, 8'($urandom_range(255)));
  endtask

  task automatic test_directed();
    send_event(CMD_STOP, 8'h00);                 // stop with empty frame
    send_event(CMD_BYTE, OP_RADIO);              // byte with no start, one-byte radio reset
    send_event(CMD_STOP, 8'hFF);
    send_event(CMD_DELAY, 8'h00);
    send_byte_frame(OP_SWITCH, 8'hFF);
    send_byte_frame(OP_MUTE, 8'h80);
    send_byte_frame(OP_MUTE, 8'h00);
    send_byte_frame(OP_STANDBY, 8'h01);
    send_event(CMD_START, 8'h00);                // four bytes, count saturates at three
    send_event(CMD_BYTE, OP_RADIO);
    for (int i = 0; i < 3; i++) send_event(CMD_BYTE, 8'h00);
    send_event(CMD_STOP, 8'h00);
  endtask

  task automatic test_random(int unsigned n_events);
    int unsigned goal;
    goal = events_sent + n_events;
    while (events_sent < goal) send_random_frame();
  endtask

  task automatic test_backpressure();
    int unsigned goal;
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_left     = HoldOffCycles;
    goal = events_sent + 24;
    while (events_sent < goal) send_random_frame();
  endtask

  // result side: check each transfer, then pick next ready
  initial begin
    prcd_status_t want;
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (res.valid === 1'b1 && res.ready === 1'b1) begin
        if (expected_status_q.size() == 0) begin
          report_mismatch("unexpected result", res.relay_pattern, 0);
        end else begin
          want = expected_status_q.pop_front();
          if (res.relay_pattern !== want.relay_pattern)
            report_mismatch("relay_pattern", res.relay_pattern, want.relay_pattern);
          if (res.standby_line !== want.standby_line)
            report_mismatch("standby_line", res.standby_line, want.standby_line);
          if (res.radio_reset_line !== want.radio_reset_line)
            report_mismatch("radio_reset_line", res.radio_reset_line, want.radio_reset_line);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= (rst_n === 1'b1) && ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((evt.valid === 1'b1 && evt.ready === 1'b1) ||
          (res.valid === 1'b1 && res.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no transfer for %0d cycles", StallLimit);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    evt.valid     = 1'b0;
    evt.command   = CMD_START;
    evt.data_byte = 8'h00;
    byte_cnt      = 2'd0;
    frame_buf[0]  = 8'h00;
    frame_buf[1]  = 8'h00;
    route_now     = ROUTING_RST;
    route_saved   = 8'h00;
    standby_now   = 1'b0;
    radio_now     = 1'b1;
    hold_left     = 0;
    events_sent   = 0;
    fail_count    = 0;
    src_idle_pct  = 31;
    sink_idle_pct = 75;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(160);
    src_idle_pct  = 75;
    sink_idle_pct = 31;
    test_random(160);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random(150);
    test_backpressure();

    evt.valid <= 1'b0;
    sink_idle_pct = 0;
    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: preamp_routing_command_decoder_unit.f
rtl/prcd_pkg.sv
rtl/prcd_if.sv
rtl/prcd_state.sv
rtl/preamp_routing_command_decoder_unit.sv
test/preamp_routing_command_decoder_unit_tb.sv
